>>> rtl/itag_pkg.sv
// Shared types and constants for the integrity tree address generator.
// Holds the sequencer state type, access kind codes, register indexes and
// the result record. No dependencies.
`timescale 1ns / 1ps

package itag_pkg;

  // Field widths of the transaction payload
  localparam int unsigned META_W  = 40;
  localparam int unsigned BYTES_W = 7;
  localparam int unsigned LEVEL_W = 4;

  // Access kind codes
  typedef enum logic [1:0] {
    KIND_MAC  = 2'd0,
    KIND_CNT  = 2'd1,
    KIND_TREE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Access sizes
  localparam logic [BYTES_W-1:0] BYTES_MAC  = 7'd8;
  localparam logic [BYTES_W-1:0] BYTES_LINE = 7'd64;
  localparam logic [BYTES_W-1:0] BYTES_ERR  = 7'd0;

  // Register indexes on the APB port (byte address 8 * index)
  localparam logic [2:0] REG_MAC_BASE     = 3'd0;
  localparam logic [2:0] REG_COUNTER_BASE = 3'd1;
  localparam logic [2:0] REG_TREE_BASE    = 3'd2;
  localparam logic [2:0] REG_ROOT_BASE    = 3'd3;
  localparam logic [2:0] REG_DATA_LIMIT   = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ERR,
    ST_MAC,
    ST_CNT,
    ST_LEAF,
    ST_END,
    ST_DIFF,
    ST_PAR,
    ST_FLUSH
  } state_t;

  // One result record
  typedef struct packed {
    logic [META_W-1:0]  meta_address;
    kind_t              access_kind;
    logic [BYTES_W-1:0] access_bytes;
    logic [LEVEL_W-1:0] tree_level;
    logic               last;
  } result_t;

endpackage

>>> rtl/integrity_tree_address_generator.sv
// Integrity tree address generator: turns one protected data write address
// into a run of MAC, counter and tree node addresses. An accepted request
// with an in-range address first scans the layer starts (one add per cycle,
// up to MAX_LAYERS checks) to find the root, then emits MAC, counter and
// leaf and walks each tree layer below the root through its layer end,
// offset and parent steps, all on one shared adder. An out-of-range address
// or a missing root gives a single error result. in_stall is high for the
// whole request. The last result leaves from a one-entry hold after the walk.
// Depends on itag_pkg.
`timescale 1ns / 1ps

module integrity_tree_address_generator #(
  parameter int unsigned MAX_LAYERS       = 10,
  parameter int unsigned LEAF_LAYER_BYTES = 33554432,
  parameter int unsigned ADDR_WIDTH       = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [39:0] in_data_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] out_meta_address,
  output logic [1:0]  out_access_kind,
  output logic [6:0]  out_access_bytes,
  output logic [3:0]  out_tree_level,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned AW  = ADDR_WIDTH;
  localparam int unsigned MW  = itag_pkg::META_W;
  localparam int unsigned CW  = (AW > MW) ? AW : MW;
  localparam int unsigned SZW = $clog2(LEAF_LAYER_BYTES + 1);
  localparam int unsigned LW  = $clog2(MAX_LAYERS + 1);

  // Configuration registers
  logic [MW-1:0] mac_base_r, counter_base_r, tree_base_r, root_base_r, data_limit_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  // Sequencer and datapath registers
  itag_pkg::state_t  state_r, state_nxt;
  logic [MW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [SZW-1:0]    size_r, size_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     diff_r, diff_nxt;
  logic [LW-1:0]     lay_r, lay_nxt;
  logic [LW-1:0]     nlay_r, nlay_nxt;
  itag_pkg::result_t pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  itag_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Shared adder
  logic [AW-1:0] opa, opb, sum;
  logic          cin;

  // Offsets derived by shifts only
  logic [MW-1:0] mac_off_w;
  logic [AW-1:0] mac_off, cnt_off, leaf_off, par_off;
  logic          out_free, go, root_hit, node_below;
  itag_pkg::result_t res_new;

  // Level of a parent: layer index plus one, cut to the field width
  function automatic logic [itag_pkg::LEVEL_W-1:0] LEVEL_W_CAST(input logic [LW-1:0] lay);
    logic [LW:0] lvl;
    lvl = {1'b0, lay} + 1'b1;
    return itag_pkg::LEVEL_W'(lvl);
  endfunction

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_base_r     <= '0;
      counter_base_r <= '0;
      tree_base_r    <= '0;
      root_base_r    <= '0;
      data_limit_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        itag_pkg::REG_MAC_BASE:     mac_base_r     <= pwdata[MW-1:0];
        itag_pkg::REG_COUNTER_BASE: counter_base_r <= pwdata[MW-1:0];
        itag_pkg::REG_TREE_BASE:    tree_base_r    <= pwdata[MW-1:0];
        itag_pkg::REG_ROOT_BASE:    root_base_r    <= pwdata[MW-1:0];
        itag_pkg::REG_DATA_LIMIT:   data_limit_r   <= pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      itag_pkg::REG_MAC_BASE:     prdata = 64'(mac_base_r);
      itag_pkg::REG_COUNTER_BASE: prdata = 64'(counter_base_r);
      itag_pkg::REG_TREE_BASE:    prdata = 64'(tree_base_r);
      itag_pkg::REG_ROOT_BASE:    prdata = 64'(root_base_r);
      itag_pkg::REG_DATA_LIMIT:   prdata = 64'(data_limit_r);
      default:                    prdata = '0;
    endcase
  end

  // Address offsets
  assign mac_off_w = (addr_r >> 8) << 5;
  assign mac_off   = AW'(mac_off_w);
  assign cnt_off   = (mac_off >> 11) << 8;
  assign leaf_off  = (cnt_off >> 11) << 8;
  assign par_off   = (diff_r >> 11) << 8;

  assign sum        = opa + opb + AW'(cin);
  assign root_hit   = (CW'(start_r) == CW'(root_base_r));
  assign node_below = (node_r < end_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign go         = !pend_v_r || out_free;

  // Sequencer: next state, adder operands and result handling
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    start_nxt     = start_r;
    size_nxt      = size_r;
    node_nxt      = node_r;
    end_nxt       = end_r;
    diff_nxt      = diff_r;
    lay_nxt       = lay_r;
    nlay_nxt      = nlay_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    opa           = start_r;
    opb           = AW'(size_r);
    cin           = 1'b0;
    res_new       = '{meta_address: MW'(sum), access_kind: itag_pkg::KIND_TREE,
                      access_bytes: itag_pkg::BYTES_LINE, tree_level: '0, last: 1'b0};

    unique case (state_r)
      itag_pkg::ST_IDLE: begin
        if (in_valid) begin
          addr_nxt  = in_data_address;
          start_nxt = AW'(tree_base_r);
          size_nxt  = SZW'(LEAF_LAYER_BYTES);
          lay_nxt   = '0;
          state_nxt = (in_data_address >= data_limit_r) ? itag_pkg::ST_ERR
                                                        : itag_pkg::ST_SCAN;
        end
      end

      // Find the layer that starts at the root
      itag_pkg::ST_SCAN: begin
        if (root_hit) begin
          nlay_nxt  = lay_r;
          state_nxt = itag_pkg::ST_MAC;
        end else if (lay_r == LW'(MAX_LAYERS - 1)) begin
          state_nxt = itag_pkg::ST_ERR;
        end else begin
          start_nxt = sum;
          size_nxt  = size_r >> 3;
          lay_nxt   = lay_r + 1'b1;
        end
      end

      // Single error result
      itag_pkg::ST_ERR: begin
        if (out_free) begin
          out_nxt = '{meta_address: '0, access_kind: itag_pkg::KIND_ERR,
                      access_bytes: itag_pkg::BYTES_ERR, tree_level: '0, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = itag_pkg::ST_IDLE;
        end
      end

      itag_pkg::ST_MAC: begin
        opa     = AW'(mac_base_r);
        opb     = mac_off;
        res_new.access_kind  = itag_pkg::KIND_MAC;
        res_new.access_bytes = itag_pkg::BYTES_MAC;
        pend_nxt   = res_new;
        pend_v_nxt = 1'b1;
        state_nxt  = itag_pkg::ST_CNT;
      end

      itag_pkg::ST_CNT: begin
        opa = AW'(counter_base_r);
        opb = cnt_off;
        res_new.access_kind = itag_pkg::KIND_CNT;
        if (go) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = res_new;
          state_nxt     = itag_pkg::ST_LEAF;
        end
      end

      itag_pkg::ST_LEAF: begin
        opa = AW'(tree_base_r);
        opb = leaf_off;
        if (go) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = res_new;
          node_nxt      = sum;
          start_nxt     = AW'(tree_base_r);
          size_nxt      = SZW'(LEAF_LAYER_BYTES);
          lay_nxt       = '0;
          state_nxt     = (nlay_r == '0) ? itag_pkg::ST_FLUSH : itag_pkg::ST_END;
        end
      end

      // Layer end
      itag_pkg::ST_END: begin
        end_nxt   = sum;
        state_nxt = itag_pkg::ST_DIFF;
      end

      // Node offset inside the layer
      itag_pkg::ST_DIFF: begin
        opa       = node_r;
        opb       = ~start_r;
        cin       = 1'b1;
        diff_nxt  = sum;
        state_nxt = itag_pkg::ST_PAR;
      end

      // Parent node, then advance to the next layer
      itag_pkg::ST_PAR: begin
        opa = end_r;
        opb = par_off;
        res_new.tree_level = LEVEL_W_CAST(lay_r);
        if (!node_below || go) begin
          if (node_below) begin
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
            pend_nxt      = res_new;
            node_nxt      = sum;
          end
          start_nxt = end_r;
          size_nxt  = size_r >> 3;
          lay_nxt   = lay_r + 1'b1;
          state_nxt = (LW'(lay_r + 1'b1) == nlay_r) ? itag_pkg::ST_FLUSH
                                                    : itag_pkg::ST_END;
        end
      end

      // Release the held result as the last of the run
      itag_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = itag_pkg::ST_IDLE;
        end
      end

      default: state_nxt = itag_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itag_pkg::ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    start_r <= start_nxt;
    size_r  <= size_nxt;
    node_r  <= node_nxt;
    end_r   <= end_nxt;
    diff_r  <= diff_nxt;
    lay_r   <= lay_nxt;
    nlay_r  <= nlay_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall         = (state_r != itag_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_meta_address = out_r.meta_address;
  assign out_access_kind  = out_r.access_kind;
  assign out_access_bytes = out_r.access_bytes;
  assign out_tree_level   = out_r.tree_level;
  assign out_last         = out_r.last;

endmodule

>>> rtl/itag_checker.sv
// Port-level checks for the integrity tree address generator.
// Sees only the top level's ports; bound to it below. Uses itag_pkg.
`timescale 1ns / 1ps

module itag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] out_meta_address,
  input logic [1:0]  out_access_kind,
  input logic [6:0]  out_access_bytes,
  input logic [3:0]  out_tree_level,
  input logic        out_last
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_meta_address) &&
      $stable(out_access_kind) && $stable(out_last))
    else $error("stalled result changed");

  // Busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy window missing");

  // Error result is an empty, final transaction
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_kind == itag_pkg::KIND_ERR |->
      out_last && out_meta_address == 40'd0 && out_access_bytes == itag_pkg::BYTES_ERR)
    else $error("malformed error result");

  // MAC access is never the end of a run and has MAC size and level zero
  a_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_kind == itag_pkg::KIND_MAC |->
      !out_last && out_access_bytes == itag_pkg::BYTES_MAC && out_tree_level == 4'd0)
    else $error("malformed MAC result");

endmodule

bind integrity_tree_address_generator itag_checker u_itag_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_meta_address (out_meta_address),
  .out_access_kind  (out_access_kind),
  .out_access_bytes (out_access_bytes),
  .out_tree_level   (out_tree_level),
  .out_last         (out_last)
);
